[hdl/i2cmw_pkg.sv]
// ----------------------------------------------------------------------------
// i2cmw_pkg
// Shared types and constants for the I2C master write pin sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmw_pkg;

    // command codes as carried on the input tuser
    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_STOP     = 2'd1,
        CMD_WRITE    = 2'd2,
        CMD_WAIT_ACK = 2'd3
    } cmd_t;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned HOLD_W        = 8;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd10;
    localparam int unsigned QUEUE_DEPTH   = 4;

    localparam int unsigned S_TDATA_W     = 16;
    localparam int unsigned M_TDATA_W     = 8;

    // step counter covers the 25 states of a byte write
    localparam int unsigned STEP_W        = 5;
    localparam logic [STEP_W-1:0] WRITE_TAIL_STEP = 5'd24;

    // bit phases within one data bit of a byte write
    typedef enum logic [1:0] {
        PH_SCL_LOW = 2'd0,
        PH_SET_SDA = 2'd1,
        PH_SCL_HI  = 2'd2
    } phase_t;

    // classified command as queued between front and back
    typedef struct packed {
        cmd_t              cmd;
        logic [BYTE_W-1:0] data_byte;
        logic              ack;      // wait-ack saw SDA low
    } cmd_item_t;

endpackage

`default_nettype wire

[hdl/i2cmw_front.sv]
// ----------------------------------------------------------------------------
// i2cmw_front
// Accepts command transactions, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmw_front #(
    parameter int unsigned DEPTH = i2cmw_pkg::QUEUE_DEPTH
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [i2cmw_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    input  wire logic [1:0]                            s_axis_tuser,
    output logic                                       q_valid,
    output i2cmw_pkg::cmd_item_t                       q_item,
    input  wire logic                                  q_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    i2cmw_pkg::cmd_item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    i2cmw_pkg::cmd_item_t in_item;
    logic                 push;

    always_comb begin
        in_item.cmd       = i2cmw_pkg::cmd_t'(s_axis_tuser);
        in_item.data_byte = s_axis_tdata[i2cmw_pkg::BYTE_W-1:0];
        in_item.ack       = ~s_axis_tdata[i2cmw_pkg::BYTE_W];
    end

    assign s_axis_tready = (count_reg != CNT_W'(DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != '0);
    assign q_item        = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[hdl/i2cmw_back.sv]
// ----------------------------------------------------------------------------
// i2cmw_back
// Expands queued commands into SCL/SDA pin states, spaced by the hold time.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmw_back (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [i2cmw_pkg::HOLD_W-1:0]          cfg_wr_data,
    input  wire logic                                  q_valid,
    input  wire i2cmw_pkg::cmd_item_t                  q_item,
    output logic                                       q_pop,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [i2cmw_pkg::M_TDATA_W-1:0]            m_axis_tdata,
    output logic                                       m_axis_tlast
);

    localparam int unsigned STEP_W = i2cmw_pkg::STEP_W;
    localparam int unsigned HOLD_W = i2cmw_pkg::HOLD_W;
    localparam int unsigned BYTE_W = i2cmw_pkg::BYTE_W;

    logic [HOLD_W-1:0]     hold_cycles_reg;
    logic [HOLD_W-1:0]     hold_cnt_reg,  hold_cnt_next;
    logic                  busy_reg,      busy_next;
    i2cmw_pkg::cmd_t       cmd_reg,       cmd_next;
    logic [BYTE_W-1:0]     byte_reg,      byte_next;
    logic                  ack_reg,       ack_next;
    logic [STEP_W-1:0]     step_reg,      step_next;
    i2cmw_pkg::phase_t     phase_reg,     phase_next;
    logic                  scl_level_reg, scl_level_next;
    logic                  sda_level_reg, sda_level_next;
    logic                  m_valid_reg,   m_valid_next;
    logic                  m_scl_reg,     m_sda_reg, m_ack_reg, m_last_reg;

    logic pin_scl, pin_sda, pin_ack, pin_last;
    logic emit;

    // pin state for the current step
    always_comb begin
        pin_scl  = 1'b0;
        pin_sda  = 1'b1;
        pin_ack  = 1'b0;
        pin_last = 1'b0;
        unique case (cmd_reg)
            i2cmw_pkg::CMD_START: begin
                priority if (step_reg == STEP_W'(0)) begin
                    pin_scl = scl_level_reg;
                    pin_sda = 1'b1;
                end else if (step_reg == STEP_W'(1)) begin
                    pin_scl = 1'b1;
                    pin_sda = 1'b1;
                end else if (step_reg == STEP_W'(2)) begin
                    pin_scl = 1'b1;
                    pin_sda = 1'b0;
                end else begin
                    pin_scl  = 1'b0;
                    pin_sda  = 1'b0;
                    pin_last = 1'b1;
                end
            end
            i2cmw_pkg::CMD_STOP: begin
                priority if (step_reg == STEP_W'(0)) begin
                    pin_scl = scl_level_reg;
                    pin_sda = 1'b0;
                end else if (step_reg == STEP_W'(1)) begin
                    pin_scl = 1'b1;
                    pin_sda = 1'b0;
                end else begin
                    pin_scl  = 1'b1;
                    pin_sda  = 1'b1;
                    pin_last = 1'b1;
                end
            end
            i2cmw_pkg::CMD_WRITE: begin
                if (step_reg == i2cmw_pkg::WRITE_TAIL_STEP) begin
                    pin_scl  = 1'b0;
                    pin_sda  = sda_level_reg;
                    pin_last = 1'b1;
                end else begin
                    unique case (phase_reg)
                        i2cmw_pkg::PH_SCL_LOW: begin
                            pin_scl = 1'b0;
                            pin_sda = sda_level_reg;
                        end
                        i2cmw_pkg::PH_SET_SDA: begin
                            pin_scl = 1'b0;
                            pin_sda = byte_reg[BYTE_W-1];
                        end
                        default: begin
                            pin_scl = 1'b1;
                            pin_sda = byte_reg[BYTE_W-1];
                        end
                    endcase
                end
            end
            default: begin
                // wait-ack: release SDA, raise SCL, then end on the sample
                priority if (step_reg == STEP_W'(0)) begin
                    pin_scl = scl_level_reg;
                    pin_sda = 1'b1;
                end else if (step_reg == STEP_W'(1)) begin
                    pin_scl  = 1'b1;
                    pin_sda  = 1'b1;
                    pin_last = ~ack_reg;
                end else begin
                    pin_scl  = 1'b0;
                    pin_sda  = 1'b1;
                    pin_ack  = 1'b1;
                    pin_last = 1'b1;
                end
            end
        endcase
    end

    assign emit  = busy_reg && (hold_cnt_reg == '0) && (!m_valid_reg || m_axis_tready);
    assign q_pop = !busy_reg && q_valid;

    always_comb begin
        busy_next      = busy_reg;
        cmd_next       = cmd_reg;
        byte_next      = byte_reg;
        ack_next       = ack_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        scl_level_next = scl_level_reg;
        sda_level_next = sda_level_reg;
        hold_cnt_next  = hold_cnt_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;

        if (q_pop) begin
            busy_next  = 1'b1;
            cmd_next   = q_item.cmd;
            byte_next  = q_item.data_byte;
            ack_next   = q_item.ack;
            step_next  = '0;
            phase_next = i2cmw_pkg::PH_SCL_LOW;
        end

        if (emit) begin
            m_valid_next   = 1'b1;
            scl_level_next = pin_scl;
            sda_level_next = pin_sda;
            step_next      = step_reg + 1'b1;
            hold_cnt_next  = (hold_cycles_reg == '0) ? '0 : hold_cycles_reg - 1'b1;
            if (phase_reg == i2cmw_pkg::PH_SCL_HI) begin
                phase_next = i2cmw_pkg::PH_SCL_LOW;
                byte_next  = {byte_reg[BYTE_W-2:0], 1'b0};
            end else begin
                phase_next = i2cmw_pkg::phase_t'(phase_reg + 1'b1);
            end
            if (pin_last) begin
                busy_next = 1'b0;
            end
        end else if (hold_cnt_reg != '0) begin
            hold_cnt_next = hold_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_cycles_reg <= i2cmw_pkg::HOLD_RESET;
            hold_cnt_reg    <= '0;
            busy_reg        <= 1'b0;
            step_reg        <= '0;
            phase_reg       <= i2cmw_pkg::PH_SCL_LOW;
            scl_level_reg   <= 1'b1;
            sda_level_reg   <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                hold_cycles_reg <= cfg_wr_data;
            end
            hold_cnt_reg  <= hold_cnt_next;
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            scl_level_reg <= scl_level_next;
            sda_level_reg <= sda_level_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        byte_reg <= byte_next;
        ack_reg  <= ack_next;
        if (emit) begin
            m_scl_reg  <= pin_scl;
            m_sda_reg  <= pin_sda;
            m_ack_reg  <= pin_ack;
            m_last_reg <= pin_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {{(i2cmw_pkg::M_TDATA_W - 3){1'b0}}, m_ack_reg, m_sda_reg, m_scl_reg};

endmodule

`default_nettype wire

[hdl/i2c_master_write_pin_sequencer_top.sv]
// ----------------------------------------------------------------------------
// i2c_master_write_pin_sequencer_top
// Write-only I2C master: command transactions in, timed pin-state
// transactions out.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata (low bit up)                | tuser | tlast
//  s_axis    | in        | data_byte[7:0], sda_in, 7'b0      | func  | -
//  m_axis    | out       | scl_out, sda_out, ack_seen, 5'b0  | -     | last
//  cfg       | in        | hold_cycles on cfg_wr_data        | -     | -
//
//  Start emits 4 states, stop 3, write byte 25, wait-ack 2 or 3. States of
//  one command are spaced by the back-end hold counter, which reloads from
//  hold_cycles on each state; the next queued command is loaded while that
//  count runs, so its first state follows the previous command's last state
//  at the same spacing or later. Commands are queued while the back end
//  works; m_axis stalls only stretch the spacing.
//  Reset leaves both lines released and hold_cycles 10.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_write_pin_sequencer_top #(
    parameter int unsigned QUEUE_DEPTH = i2cmw_pkg::QUEUE_DEPTH
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [i2cmw_pkg::HOLD_W-1:0]          cfg_wr_data,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // data_byte[7:0], sda_in[8], zero padding
    input  wire logic [i2cmw_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // func[1:0]
    input  wire logic [1:0]                            s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // scl_out[0], sda_out[1], ack_seen[2], zero padding
    output logic [i2cmw_pkg::M_TDATA_W-1:0]            m_axis_tdata,
    output logic                                       m_axis_tlast
);

    logic                 q_valid;
    logic                 q_pop;
    i2cmw_pkg::cmd_item_t q_item;

    i2cmw_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    i2cmw_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
